@@ hw/rtl/apf_pkg.sv @@
// apf_pkg: shared constants and types for the articulation point finder
// holds the search frame layout and operation codes; no dependencies
package apf_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int VIDX_W       = 4;
   localparam int CNT_W        = 5;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   typedef logic [MAX_VERTICES-1:0] row_type;
   typedef logic [VIDX_W-1:0]       vidx_type;
   typedef logic [CNT_W-1:0]        cnt_type;

   typedef struct packed {
      vidx_type vertex;
      vidx_type parent;
      logic     has_parent;
      cnt_type  cursor;
      cnt_type  children;
      cnt_type  disc;
      cnt_type  low;
      row_type  row;
   } frame_type;

endpackage

@@ hw/rtl/apf_adj_store.sv @@
// apf_adj_store: adjacency matrix storage, one row per entry
// single write port, registered read port; depends on apf_pkg
module apf_adj_store (
   input  logic             clock,
   input  logic             wr_en,
   input  apf_pkg::vidx_type wr_addr,
   input  apf_pkg::row_type  wr_row,
   input  apf_pkg::vidx_type rd_addr,
   output apf_pkg::row_type  rd_row
);

   apf_pkg::row_type adj_mem [apf_pkg::MAX_VERTICES];
   apf_pkg::row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_row;
      end
      rd_row_ff <= adj_mem[rd_addr];
   end

   assign rd_row = rd_row_ff;

endmodule

@@ hw/rtl/articulation_point_finder.sv @@
// articulation_point_finder: cut vertex search over a loaded adjacency matrix
// a row load writes one adjacency row from idle; a run scans the neighbors of each of the n vertices
// one at a time, with a back-edge check step for each visited neighbor other than the parent
// the input stalls during a run; the result register frees the input side early
// synchronous active-high reset: sequencer idle, no result pending, vertex count 16
// depends on apf_pkg and apf_adj_store
module articulation_point_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [0:0]  req_operation,
   input  logic [3:0]  req_row_index,
   input  logic [15:0] req_row_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_cut_mask,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROOT  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_BACK  = 3'd4;
   localparam logic [2:0] S_POP   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]           state_ff, state_in;
   apf_pkg::cnt_type     vcount_ff;
   apf_pkg::cnt_type     root_ff, root_in;
   apf_pkg::cnt_type     depth_ff, depth_in;
   apf_pkg::cnt_type     count_ff, count_in;
   apf_pkg::row_type     visited_ff, visited_in;
   apf_pkg::row_type     cut_ff, cut_in;
   apf_pkg::frame_type   top_ff, top_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   apf_pkg::row_type     rsp_mask_ff, rsp_mask_in;

   apf_pkg::cnt_type     n_used;
   apf_pkg::cnt_type     depth_m1, depth_m2, count_p1;
   apf_pkg::vidx_type    cur_idx;
   logic                 req_xfer;

   logic                 adj_we;
   apf_pkg::vidx_type    adj_ra;
   apf_pkg::row_type     adj_row;

   apf_pkg::frame_type   stk_mem [apf_pkg::MAX_VERTICES];
   logic                 stk_we;
   apf_pkg::vidx_type    stk_wa, stk_ra;
   apf_pkg::frame_type   stk_wd, stk_rd_ff;

   apf_pkg::cnt_type     disc_mem [apf_pkg::MAX_VERTICES];
   logic                 disc_we;
   apf_pkg::vidx_type    disc_wa;
   apf_pkg::cnt_type     disc_rd_ff;

   assign n_used   = (vcount_ff > apf_pkg::cnt_type'(apf_pkg::MAX_VERTICES))
                   ? apf_pkg::cnt_type'(apf_pkg::MAX_VERTICES) : vcount_ff;
   assign depth_m1 = depth_ff - apf_pkg::cnt_type'(1);
   assign depth_m2 = depth_ff - apf_pkg::cnt_type'(2);
   assign count_p1 = count_ff + apf_pkg::cnt_type'(1);
   assign cur_idx  = top_ff.cursor[apf_pkg::VIDX_W-1:0];
   assign stk_wa   = depth_m1[apf_pkg::VIDX_W-1:0];
   assign stk_ra   = depth_m2[apf_pkg::VIDX_W-1:0];

   assign req_stall    = (state_ff != S_IDLE);
   assign req_xfer     = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cut_mask = rsp_mask_ff;

   apf_adj_store u_adj (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (req_row_index),
      .wr_row  (req_row_bits),
      .rd_addr (adj_ra),
      .rd_row  (adj_row)
   );

   // frame stack and discovery numbers
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stk_mem[stk_ra];
      if (disc_we) begin
         disc_mem[disc_wa] <= count_p1;
      end
      disc_rd_ff <= disc_mem[cur_idx];
   end

   always_comb begin
      state_in     = state_ff;
      root_in      = root_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      visited_in   = visited_ff;
      cut_in       = cut_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mask_in  = rsp_mask_ff;
      adj_we       = 1'b0;
      adj_ra       = cur_idx;
      stk_we       = 1'b0;
      stk_wd       = top_ff;
      disc_we      = 1'b0;
      disc_wa      = cur_idx;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_operation == apf_pkg::OP_LOAD) begin
                  adj_we = 1'b1;
               end else begin
                  visited_in = '0;
                  cut_in     = '0;
                  count_in   = '0;
                  depth_in   = '0;
                  root_in    = '0;
                  state_in   = S_ROOT;
               end
            end
         end
         S_ROOT: begin
            adj_ra = root_ff[apf_pkg::VIDX_W-1:0];
            if (root_ff >= n_used) begin
               state_in = S_DONE;
            end else if (visited_ff[root_ff[apf_pkg::VIDX_W-1:0]]) begin
               root_in = root_ff + apf_pkg::cnt_type'(1);
            end else begin
               disc_we           = 1'b1;
               disc_wa           = root_ff[apf_pkg::VIDX_W-1:0];
               count_in          = count_p1;
               visited_in[root_ff[apf_pkg::VIDX_W-1:0]] = 1'b1;
               top_in.vertex     = root_ff[apf_pkg::VIDX_W-1:0];
               top_in.parent     = '0;
               top_in.has_parent = 1'b0;
               top_in.cursor     = '0;
               top_in.children   = '0;
               top_in.disc       = count_p1;
               top_in.low        = count_p1;
               depth_in          = apf_pkg::cnt_type'(1);
               state_in          = S_FETCH;
            end
         end
         S_FETCH: begin
            top_in.row = adj_row;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            if (top_ff.cursor >= n_used) begin
               if (depth_ff == apf_pkg::cnt_type'(1)) begin
                  depth_in = '0;
                  root_in  = root_ff + apf_pkg::cnt_type'(1);
                  state_in = S_ROOT;
               end else begin
                  state_in = S_POP;
               end
            end else begin
               top_in.cursor = top_ff.cursor + apf_pkg::cnt_type'(1);
               if (cur_idx != top_ff.vertex && top_ff.row[cur_idx]) begin
                  if (!visited_ff[cur_idx]) begin
                     // descend into an unvisited neighbor
                     stk_we            = 1'b1;
                     stk_wd.cursor     = top_ff.cursor + apf_pkg::cnt_type'(1);
                     stk_wd.children   = top_ff.children + apf_pkg::cnt_type'(1);
                     disc_we           = 1'b1;
                     count_in          = count_p1;
                     visited_in[cur_idx] = 1'b1;
                     top_in.vertex     = cur_idx;
                     top_in.parent     = top_ff.vertex;
                     top_in.has_parent = 1'b1;
                     top_in.cursor     = '0;
                     top_in.children   = '0;
                     top_in.disc       = count_p1;
                     top_in.low        = count_p1;
                     depth_in          = depth_ff + apf_pkg::cnt_type'(1);
                     state_in          = S_FETCH;
                  end else if (!top_ff.has_parent || cur_idx != top_ff.parent) begin
                     state_in = S_BACK;
                  end
               end
            end
         end
         S_BACK: begin
            if (disc_rd_ff < top_ff.low) begin
               top_in.low = disc_rd_ff;
            end
            state_in = S_SCAN;
         end
         S_POP: begin
            top_in = stk_rd_ff;
            if (top_ff.low < stk_rd_ff.low) begin
               top_in.low = top_ff.low;
            end
            if (stk_rd_ff.has_parent) begin
               if (top_ff.low >= stk_rd_ff.disc) begin
                  cut_in[stk_rd_ff.vertex] = 1'b1;
               end
            end else if (stk_rd_ff.children > apf_pkg::cnt_type'(1)) begin
               cut_in[stk_rd_ff.vertex] = 1'b1;
            end
            depth_in = depth_m1;
            state_in = S_SCAN;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = cut_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= apf_pkg::cnt_type'(16);
         visited_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         visited_ff   <= visited_in;
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
      end
      root_ff     <= root_in;
      depth_ff    <= depth_in;
      count_ff    <= count_in;
      cut_ff      <= cut_in;
      top_ff      <= top_in;
      rsp_mask_ff <= rsp_mask_in;
   end

endmodule
